### sv/i2cbs_pkg.sv
// Shared types, command codes and the phase-count table for the I2C bit sequencer.
// No dependencies; used by scoped names in the front, queue, back, top level and bench.
package i2cbs_pkg;

	localparam int TICK_W = 16;
	localparam logic [TICK_W-1:0] RESET_TICKS = 16'd1000;

	// command codes carried in the kind field
	localparam logic [2:0] KIND_NONE  = 3'd0;
	localparam logic [2:0] KIND_START = 3'd1;
	localparam logic [2:0] KIND_STOP  = 3'd2;
	localparam logic [2:0] KIND_SEND  = 3'd3;
	localparam logic [2:0] KIND_RECV  = 3'd4;
	localparam logic [2:0] KIND_SACK  = 3'd5;
	localparam logic [2:0] KIND_RACK  = 3'd6;

	// classified input word as it travels through the queue
	typedef struct packed {
		logic       cmd;    // kind is a real command
		logic [2:0] kind;
		logic [7:0] shift;  // byte to send, or ack level in bit 0
		logic       sda;    // sampled SDA level this tick
	} item_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

	function automatic logic [4:0] phase_count(input logic [2:0] kind);
		logic [4:0] n;
		n = 5'd0;
		unique case (kind)
			KIND_START: n = 5'd4;
			KIND_STOP:  n = 5'd3;
			KIND_SEND:  n = 5'd24;
			KIND_RECV:  n = 5'd25;
			KIND_SACK:  n = 5'd3;
			KIND_RACK:  n = 5'd4;
			default:    n = 5'd0;
		endcase
		return n;
	endfunction

endpackage

### sv/i2cbs_in_if.sv
// Input channel of the I2C bit sequencer: valid/ready plus one tick's word.
// Depends on nothing.
interface i2cbs_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic [7:0] tx_byte;
	logic       tx_ack;
	logic       sda_in;

	modport source (output valid, kind, tx_byte, tx_ack, sda_in, input ready);
	modport sink   (input valid, kind, tx_byte, tx_ack, sda_in, output ready);
endinterface

### sv/i2cbs_out_if.sv
// Result channel of the I2C bit sequencer: valid/ready plus one tick's result word.
// Depends on nothing.
interface i2cbs_out_if;
	logic       valid;
	logic       ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       rx_ack;
	logic       rejected;

	modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
		rejected, input ready);
	modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, rx_ack,
		rejected, output ready);
endinterface

### sv/i2cbs_front.sv
// Front end: takes input words, classifies the command and pushes them into the queue.
// Depends on i2cbs_pkg and i2cbs_in_if.
module i2cbs_front (
	i2cbs_in_if.sink          req,
	input  i2cbs_pkg::qstat_t qstat,
	output logic              push,
	output i2cbs_pkg::item_t  item
);

	logic is_cmd;

	always_comb begin
		// kind 7 is not a command
		is_cmd = (req.kind != i2cbs_pkg::KIND_NONE) && (req.kind <= i2cbs_pkg::KIND_RACK);
		item.cmd  = is_cmd;
		item.kind = req.kind;
		item.sda  = req.sda_in;
		unique case (req.kind)
			i2cbs_pkg::KIND_SEND: item.shift = req.tx_byte;
			i2cbs_pkg::KIND_SACK: item.shift = {7'd0, req.tx_ack};
			default:              item.shift = 8'd0;
		endcase
	end

	assign req.ready = !qstat.full;
	assign push      = req.valid && !qstat.full;

endmodule

### sv/i2cbs_queue.sv
// Short FIFO between front and back of the I2C bit sequencer.
// Depends on i2cbs_pkg.
module i2cbs_queue #(
	parameter int DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  i2cbs_pkg::item_t  wdata,
	input  logic              pop,
	output i2cbs_pkg::item_t  rdata,
	output i2cbs_pkg::qstat_t qstat
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	i2cbs_pkg::item_t mem_q [DEPTH];
	logic [IW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata          = mem_q[rd_q];
	assign qstat.full     = (cnt_q == FULL);
	assign qstat.nonempty = (cnt_q != '0);

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= FULL)
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != '0)
		else $error("pop from empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("push did not raise count");
`endif

endmodule

### sv/i2cbs_back.sv
// Back end: pops classified words, runs the pin sequence and registers one result per word.
// Depends on i2cbs_pkg and i2cbs_out_if.
module i2cbs_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [i2cbs_pkg::TICK_W-1:0]    len,
	input  i2cbs_pkg::item_t                head,
	input  i2cbs_pkg::qstat_t               qstat,
	output logic                            pop,
	i2cbs_out_if.source                     rsp
);

	localparam logic [2:0] NONE = i2cbs_pkg::KIND_NONE;

	// sequencer state
	logic                         scl_q, sda_q, ack_q;
	logic [2:0]                   act_q;
	logic [4:0]                   ph_q;
	logic [i2cbs_pkg::TICK_W-1:0] tick_q;
	logic [7:0]                   sh_q;
	logic [1:0]                   sub_q;   // bit step, TX data/SCL hi/lo, RX SCL hi/sample/lo
	logic [2:0]                   bit_q;   // bit number, MSB first

	// output register
	logic       ovalid_q;
	logic       oscl_q, osda_q, obusy_q, odone_q, orxa_q, orej_q;
	logic [7:0] orxb_q;

	// working values for this word
	logic                         start, rej, busy, done, rxa;
	logic [7:0]                   rxb;
	logic [2:0]                   a, act_n;
	logic [4:0]                   p, ph_n;
	logic [i2cbs_pkg::TICK_W-1:0] t, tnext, tick_n;
	logic [7:0]                   sh, sh_n;
	logic [1:0]                   sub, sub_n;
	logic [2:0]                   bitn, bit_n;
	logic                         scl_n, sda_n, ack_n;

	always_comb begin
		pop   = qstat.nonempty && (!ovalid_q || rsp.ready);
		rej   = (act_q != NONE) && head.cmd;
		start = (act_q == NONE) && head.cmd;
		a     = start ? head.kind  : act_q;
		p     = start ? 5'd0       : ph_q;
		t     = start ? '0         : tick_q;
		sh    = start ? head.shift : sh_q;
		sub   = start ? 2'd0       : sub_q;
		bitn  = start ? 3'd0       : bit_q;

		scl_n  = scl_q;
		sda_n  = sda_q;
		ack_n  = ack_q;
		sh_n   = sh;
		act_n  = a;
		ph_n   = p;
		tick_n = t;
		sub_n  = sub;
		bit_n  = bitn;
		busy   = 1'b0;
		done   = 1'b0;
		rxb    = 8'd0;
		rxa    = 1'b0;
		tnext  = t + 1'b1;

		if (a != NONE) begin
			busy = 1'b1;
			// a phase acts on its first tick only
			if (t == '0) begin
				unique case (a)
					i2cbs_pkg::KIND_START: begin
						priority if (p == 5'd0) sda_n = 1'b1;
						else if (p == 5'd1)     scl_n = 1'b1;
						else if (p == 5'd2)     sda_n = 1'b0;
						else                    scl_n = 1'b0;
					end
					i2cbs_pkg::KIND_STOP: begin
						priority if (p == 5'd0) sda_n = 1'b0;
						else if (p == 5'd1)     scl_n = 1'b1;
						else                    sda_n = 1'b1;
					end
					i2cbs_pkg::KIND_SEND: begin
						priority if (sub == 2'd0) sda_n = sh[3'd7 - bitn];
						else if (sub == 2'd1)     scl_n = 1'b1;
						else                      scl_n = 1'b0;
					end
					i2cbs_pkg::KIND_RECV: begin
						priority if (p == 5'd0) sda_n = 1'b1;
						else if (sub == 2'd0)   scl_n = 1'b1;
						else if (sub == 2'd1) begin
							if (head.sda) sh_n[3'd7 - bitn] = 1'b1;
						end else                scl_n = 1'b0;
					end
					i2cbs_pkg::KIND_SACK: begin
						priority if (p == 5'd0) sda_n = sh[0];
						else if (p == 5'd1)     scl_n = 1'b1;
						else                    scl_n = 1'b0;
					end
					i2cbs_pkg::KIND_RACK: begin
						priority if (p == 5'd0) sda_n = 1'b1;
						else if (p == 5'd1)     scl_n = 1'b1;
						else if (p == 5'd2)     ack_n = head.sda;
						else                    scl_n = 1'b0;
					end
					default: ;
				endcase
			end

			if (tnext >= len) begin
				tick_n = '0;
				ph_n   = p + 1'b1;
				// the leading SDA release of receive byte is not part of a bit
				if (!(a == i2cbs_pkg::KIND_RECV && p == 5'd0)) begin
					if (sub == 2'd2) begin
						sub_n = 2'd0;
						bit_n = bitn + 1'b1;
					end else begin
						sub_n = sub + 1'b1;
					end
				end
				if (ph_n >= i2cbs_pkg::phase_count(a)) begin
					done  = 1'b1;
					rxb   = (a == i2cbs_pkg::KIND_RECV) ? sh_n : 8'd0;
					rxa   = (a == i2cbs_pkg::KIND_RACK) ? ack_n : 1'b0;
					act_n = NONE;
					ph_n  = 5'd0;
				end
			end else begin
				tick_n = tnext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ack_q    <= 1'b1;
			act_q    <= NONE;
			ph_q     <= 5'd0;
			tick_q   <= '0;
			sh_q     <= 8'd0;
			sub_q    <= 2'd0;
			bit_q    <= 3'd0;
			ovalid_q <= 1'b0;
		end else begin
			if (pop) begin
				scl_q    <= scl_n;
				sda_q    <= sda_n;
				ack_q    <= ack_n;
				act_q    <= act_n;
				ph_q     <= ph_n;
				tick_q   <= tick_n;
				sh_q     <= sh_n;
				sub_q    <= sub_n;
				bit_q    <= bit_n;
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			oscl_q  <= scl_n;
			osda_q  <= sda_n;
			obusy_q <= busy;
			odone_q <= done;
			orxb_q  <= rxb;
			orxa_q  <= rxa;
			orej_q  <= rej;
		end
	end

	assign rsp.valid    = ovalid_q;
	assign rsp.scl_out  = oscl_q;
	assign rsp.sda_out  = osda_q;
	assign rsp.busy_res = obusy_q;
	assign rsp.done_res = odone_q;
	assign rsp.rx_byte  = orxb_q;
	assign rsp.rx_ack   = orxa_q;
	assign rsp.rejected = orej_q;

`ifndef SYNTHESIS
	a_rej_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && (orej_q || odone_q) |-> obusy_q)
		else $error("reject or done without busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop && done |=> act_q == NONE && ph_q == 5'd0)
		else $error("sequencer not idle after done");
	a_rxb_done: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !odone_q |-> orxb_q == 8'd0 && !orxa_q)
		else $error("received data outside done word");
`endif

endmodule

### sv/i2c_master_bit_sequencer_unit.sv
// Top level of the I2C master bit sequencer: phase length register, front, queue, back.
// Depends on i2cbs_pkg, i2cbs_in_if, i2cbs_out_if, i2cbs_front, i2cbs_queue, i2cbs_back.
//
// Usage:
//  - req carries one word per SCL/SDA tick: kind (0 none, 1 start, 2 stop, 3 send byte,
//    4 receive byte, 5 send ack, 6 receive ack), tx_byte, tx_ack and the sampled sda_in.
//  - rsp returns exactly one word per accepted input word, in order: pin levels,
//    busy, a done pulse on the last tick of a command with rx_byte / rx_ack, and
//    rejected when a command arrived while another was running.
//  - cfg_we / cfg_wdata write phase_ticks (ticks per phase, 0 acts as 1); write it
//    only while no word is in flight.
//  - Path: an accepted word enters the queue, is popped by the sequencer once the
//    result register is free, and its result is registered there and shown on rsp.
//  - Throughput: one word per cycle while rsp takes results; the sequencer state update
//    is one tick counter compare and a phase step per word, so nothing iterates.
//  - Stall: while rsp is held off, the result register keeps its word and the queue
//    (QUEUE_DEPTH words) keeps taking input; req.ready drops only when it is full.
//  - Reset: both pins released high, no command active, phase_ticks back to 1000,
//    queue and result register empty.
module i2c_master_bit_sequencer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	i2cbs_in_if.sink                     req,
	i2cbs_out_if.source                  rsp,
	input  logic                         cfg_we,
	input  logic [i2cbs_pkg::TICK_W-1:0] cfg_wdata
);

	logic [i2cbs_pkg::TICK_W-1:0] ticks_q;
	logic [i2cbs_pkg::TICK_W-1:0] len;

	i2cbs_pkg::item_t  push_item, head_item;
	i2cbs_pkg::qstat_t qstat;
	logic              push, pop;

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= i2cbs_pkg::RESET_TICKS;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	// zero length runs as a single tick
	assign len = (ticks_q == '0) ? i2cbs_pkg::TICK_W'(1) : ticks_q;

	i2cbs_front u_front (
		.req   (req),
		.qstat (qstat),
		.push  (push),
		.item  (push_item)
	);

	i2cbs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_item),
		.pop    (pop),
		.rdata  (head_item),
		.qstat  (qstat)
	);

	i2cbs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.len    (len),
		.head   (head_item),
		.qstat  (qstat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

### bench/i2c_master_bit_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for i2c_master_bit_sequencer_unit: directed table, then random phases.
// Depends on i2cbs_pkg, i2cbs_in_if, i2cbs_out_if and the unit itself.
module i2c_master_bit_sequencer_unit_tb;

	// kind 7 is not a command: the unit must neither start nor reject on it
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	// cycles without any handshake before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// long result-side hold-off, sized well past the queue depth
	localparam int HOLD_CYCLES = 48;

	// one result word as the unit returns it
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       rx_ack;
		logic       rejected;
	} pin_word_t;

	// directed stimulus row: optional phase length write, then reps copies of one word
	typedef struct {
		bit         set_cfg;
		logic [15:0] cfg_val;
		logic [2:0] kind;
		logic [7:0] txb;
		logic       txa;
		logic       sda;
		int         reps;
		bit         typed;
		pin_word_t  want;
	} dir_row_t;

	// values that can be read off directly: bus idle, and the first ticks of start
	localparam pin_word_t BUS_IDLE    = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam pin_word_t START_FIRST = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam pin_word_t START_REJ   = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

	// phases per command, indexed by kind
	localparam int unsigned CMD_PHASES [8] = '{0, 4, 3, 24, 25, 3, 4, 0};

	// random part: phase length per stretch and words per stretch; the last one
	// runs at the top extreme and without idling
	localparam int N_STRETCH = 7;
	localparam logic [15:0] STRETCH_TICKS [N_STRETCH] = '{16'd3, 16'd1, 16'd0, 16'd2,
		16'd7, 16'd1, 16'd65535};
	localparam int STRETCH_WORDS [N_STRETCH] = '{60, 70, 60, 60, 60, 60, 80};

	localparam int DIR_ROWS = 24;
	dir_row_t dir_plan [DIR_ROWS] = '{
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b0, 1,  1'b1, BUS_IDLE},
		'{1'b0, 16'd0, KIND_UNUSED,           8'hFF, 1'b1, 1'b1, 1,  1'b1, BUS_IDLE},
		'{1'b1, 16'd1, i2cbs_pkg::KIND_START, 8'h00, 1'b0, 1'b0, 1,  1'b1, START_FIRST},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_START, 8'hFF, 1'b1, 1'b1, 1,  1'b1, START_REJ},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b1, 2,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_SEND,  8'hFF, 1'b0, 1'b0, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b1, 23, 1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_SEND,  8'h00, 1'b1, 1'b1, 24, 1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_RECV,  8'h00, 1'b0, 1'b1, 25, 1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_RECV,  8'hFF, 1'b1, 1'b0, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b0, 24, 1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_SACK,  8'hFF, 1'b0, 1'b1, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b0, 2,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_SACK,  8'h00, 1'b1, 1'b0, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b1, 1'b1, 2,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_RACK,  8'h00, 1'b0, 1'b0, 4,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_RACK,  8'hFF, 1'b1, 1'b1, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b1, 3,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_STOP,  8'h00, 1'b0, 1'b0, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b0, 2,  1'b0, '0},
		'{1'b1, 16'd0, i2cbs_pkg::KIND_START, 8'h00, 1'b0, 1'b0, 1,  1'b0, '0},
		'{1'b0, 16'd0, KIND_UNUSED,           8'hFF, 1'b1, 1'b0, 3,  1'b0, '0},
		'{1'b1, 16'd2, i2cbs_pkg::KIND_STOP,  8'h00, 1'b0, 1'b1, 1,  1'b0, '0},
		'{1'b0, 16'd0, i2cbs_pkg::KIND_NONE,  8'h00, 1'b0, 1'b1, 5,  1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [i2cbs_pkg::TICK_W-1:0] cfg_wdata;

	i2cbs_in_if  req_ch ();
	i2cbs_out_if rsp_ch ();

	i2c_master_bit_sequencer_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Bus model: own copy of the sequencer state, advanced once per accepted
	// word, in the order the unit takes them.
	// ---------------------------------------------------------------------
	logic [15:0]  seq_ticks = i2cbs_pkg::RESET_TICKS;
	logic         bus_scl   = 1'b1;
	logic         bus_sda   = 1'b1;
	logic [2:0]   cur_cmd   = i2cbs_pkg::KIND_NONE;
	int unsigned  phase_no  = 0;
	int unsigned  tick_no   = 0;
	logic [7:0]   shift_reg = 8'h00;
	logic         ack_level = 1'b1;

	pin_word_t pin_words_due [$];   // results owed by the unit, oldest first

	// pin write or SDA read of the current phase; runs on the phase's first tick
	function automatic void run_bus_phase(logic sda);
		int unsigned slot;
		int unsigned bitn;
		int unsigned sub;
		slot = phase_no;
		case (cur_cmd)
			i2cbs_pkg::KIND_START: begin
				if (slot == 0) bus_sda = 1'b1;
				else if (slot == 1) bus_scl = 1'b1;
				else if (slot == 2) bus_sda = 1'b0;
				else bus_scl = 1'b0;
			end
			i2cbs_pkg::KIND_STOP: begin
				if (slot == 0) bus_sda = 1'b0;
				else if (slot == 1) bus_scl = 1'b1;
				else bus_sda = 1'b1;
			end
			i2cbs_pkg::KIND_SEND: begin
				bitn = (slot / 3) % 8;
				sub  = slot % 3;
				// MSB first
				if (sub == 0) bus_sda = shift_reg[7 - bitn];
				else if (sub == 1) bus_scl = 1'b1;
				else bus_scl = 1'b0;
			end
			i2cbs_pkg::KIND_RECV: begin
				if (slot == 0) begin
					bus_sda = 1'b1;   // release SDA before clocking in
				end else begin
					bitn = ((slot - 1) / 3) % 8;
					sub  = (slot - 1) % 3;
					if (sub == 0) bus_scl = 1'b1;
					else if (sub == 1) begin
						if (sda) shift_reg[7 - bitn] = 1'b1;
					end else bus_scl = 1'b0;
				end
			end
			i2cbs_pkg::KIND_SACK: begin
				if (slot == 0) bus_sda = shift_reg[0];
				else if (slot == 1) bus_scl = 1'b1;
				else bus_scl = 1'b0;
			end
			i2cbs_pkg::KIND_RACK: begin
				if (slot == 0) bus_sda = 1'b1;
				else if (slot == 1) bus_scl = 1'b1;
				else if (slot == 2) ack_level = sda;
				else bus_scl = 1'b0;
			end
			default: ;
		endcase
	endfunction

	// one tick of the sequencer; returns the pin word it produces
	function automatic pin_word_t tick_bus(logic [2:0] kind, logic [7:0] txb, logic txa,
		logic sda);
		pin_word_t   r;
		int unsigned span;
		logic        is_cmd;
		r = '0;
		span = (seq_ticks == 16'd0) ? 1 : seq_ticks;   // zero length acts as one
		is_cmd = (kind >= i2cbs_pkg::KIND_START) && (kind <= i2cbs_pkg::KIND_RACK);
		if (cur_cmd != i2cbs_pkg::KIND_NONE) begin
			// any command on a busy tick, done tick included, is turned away
			if (is_cmd) r.rejected = 1'b1;
		end else if (is_cmd) begin
			cur_cmd  = kind;
			phase_no = 0;
			tick_no  = 0;
			if (kind == i2cbs_pkg::KIND_SEND) shift_reg = txb;
			else if (kind == i2cbs_pkg::KIND_SACK) shift_reg = {7'd0, txa};
			else shift_reg = 8'h00;
		end
		if (cur_cmd != i2cbs_pkg::KIND_NONE) begin
			r.busy_res = 1'b1;
			if (tick_no == 0) run_bus_phase(sda);
			tick_no++;
			if (tick_no >= span) begin
				tick_no = 0;
				phase_no++;
				if (phase_no >= CMD_PHASES[cur_cmd]) begin
					r.done_res = 1'b1;
					if (cur_cmd == i2cbs_pkg::KIND_RECV) r.rx_byte = shift_reg;
					if (cur_cmd == i2cbs_pkg::KIND_RACK) r.rx_ack = ack_level;
					cur_cmd  = i2cbs_pkg::KIND_NONE;
					phase_no = 0;
				end
			end
		end
		r.scl_out = bus_scl;
		r.sda_out = bus_sda;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------
	int fails      = 0;
	int words_in   = 0;
	int words_out  = 0;
	int cmds_done  = 0;
	int cmds_turned = 0;
	int quiet      = 0;

	task automatic note_mismatch(string what, logic [15:0] got, logic [15:0] want);
		fails++;
		$display("mismatch @%0t word %0d %s: got %h want %h", $realtime, words_out, what,
			got, want);
	endtask

	task automatic check_pin_word(pin_word_t got, pin_word_t want);
		if (got.scl_out !== want.scl_out)
			note_mismatch("scl_out", 16'(got.scl_out), 16'(want.scl_out));
		if (got.sda_out !== want.sda_out)
			note_mismatch("sda_out", 16'(got.sda_out), 16'(want.sda_out));
		if (got.busy_res !== want.busy_res)
			note_mismatch("busy_res", 16'(got.busy_res), 16'(want.busy_res));
		if (got.done_res !== want.done_res)
			note_mismatch("done_res", 16'(got.done_res), 16'(want.done_res));
		if (got.rx_byte !== want.rx_byte)
			note_mismatch("rx_byte", 16'(got.rx_byte), 16'(want.rx_byte));
		if (got.rx_ack !== want.rx_ack)
			note_mismatch("rx_ack", 16'(got.rx_ack), 16'(want.rx_ack));
		if (got.rejected !== want.rejected)
			note_mismatch("rejected", 16'(got.rejected), 16'(want.rejected));
	endtask

	// driver-side tag: the word on req carries a typed-in expectation
	bit        typed_on = 1'b0;
	pin_word_t typed_want = '0;

	// Everything observable happens at the rising edge: result words are
	// checked first (they belong to older input words), then the accepted
	// input word is run through the bus model, then any register write.
	always @(posedge clk) begin
		pin_word_t got;
		pin_word_t want;
		pin_word_t pred;
		if (!arst_n) begin
			seq_ticks = i2cbs_pkg::RESET_TICKS;
			bus_scl   = 1'b1;
			bus_sda   = 1'b1;
			cur_cmd   = i2cbs_pkg::KIND_NONE;
			phase_no  = 0;
			tick_no   = 0;
			shift_reg = 8'h00;
			ack_level = 1'b1;
			quiet     = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = '{rsp_ch.scl_out, rsp_ch.sda_out, rsp_ch.busy_res, rsp_ch.done_res,
					rsp_ch.rx_byte, rsp_ch.rx_ack, rsp_ch.rejected};
				if (pin_words_due.size() == 0) begin
					note_mismatch("word with nothing owed", 16'd0, 16'd0);
				end else begin
					want = pin_words_due.pop_front();
					check_pin_word(got, want);
				end
				if (got.done_res === 1'b1) cmds_done++;
				if (got.rejected === 1'b1) cmds_turned++;
				words_out++;
			end
			if (req_ch.valid && req_ch.ready) begin
				pred = tick_bus(req_ch.kind, req_ch.tx_byte, req_ch.tx_ack, req_ch.sda_in);
				pin_words_due.push_back(typed_on ? typed_want : pred);
				words_in++;
			end
			if (cfg_we) seq_ticks = cfg_wdata;

			// hang detection: any handshake on either side resets the count
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
			else quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("watchdog: %0d cycles without a handshake, %0d words owed", quiet,
					pin_words_due.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Result side: random stall bursts, plus one long hold-off on request so
	// the internal queue fills and req.ready drops.
	// ---------------------------------------------------------------------
	bit sink_gaps   = 1'b0;
	int hold_asks   = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int stall_left  = 0;

	always @(negedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served = hold_asks;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 5);   // random-length stall burst
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------------
	bit src_gaps = 1'b0;

	task automatic idle_src(int n);
		repeat (n) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
		end
	endtask

	// offer one word at the falling edge and hold it until taken
	task automatic send_word(logic [2:0] k, logic [7:0] b, logic a, logic s, bit typed,
		pin_word_t want);
		@(negedge clk);
		req_ch.valid   <= 1'b1;
		req_ch.kind    <= k;
		req_ch.tx_byte <= b;
		req_ch.tx_ack  <= a;
		req_ch.sda_in  <= s;
		typed_on   = typed;
		typed_want = want;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		if (src_gaps && $urandom_range(0, 5) == 0) idle_src($urandom_range(1, 6));
	endtask

	// drain every owed word, then tick the bus with empty words until no
	// command is running; ends at a falling edge with req idle
	task automatic settle_bus();
		idle_src(1);
		while (1) begin
			while (pin_words_due.size() != 0) @(negedge clk);
			if (cur_cmd == i2cbs_pkg::KIND_NONE) break;
			send_word(i2cbs_pkg::KIND_NONE, 8'h00, 1'b0, 1'($urandom), 1'b0, '0);
			idle_src(1);
		end
	endtask

	task automatic write_ticks(logic [15:0] v);
		settle_bus();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		int          row;
		int          rep;
		int          stretch;
		int          sent;
		int          fill;
		int unsigned span;
		int unsigned pick;
		logic [2:0]  k;
		logic [15:0] eff;

		// request side known from time zero; rsp ready follows from the
		// first falling edge, well inside reset
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.kind    = i2cbs_pkg::KIND_NONE;
		req_ch.tx_byte = 8'h00;
		req_ch.tx_ack  = 1'b0;
		req_ch.sda_in  = 1'b1;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed table: idle words at reset length, then every command at
		// short lengths, rejects on busy and done ticks, kind 7 while busy
		for (row = 0; row < DIR_ROWS; row++) begin
			if (dir_plan[row].set_cfg) write_ticks(dir_plan[row].cfg_val);
			for (rep = 0; rep < dir_plan[row].reps; rep++)
				send_word(dir_plan[row].kind, dir_plan[row].txb, dir_plan[row].txa,
					dir_plan[row].sda, dir_plan[row].typed, dir_plan[row].want);
		end

		// random stretches, each at its own phase length
		for (stretch = 0; stretch < N_STRETCH; stretch++) begin
			write_ticks(STRETCH_TICKS[stretch]);
			@(posedge clk);
			src_gaps  = (stretch != N_STRETCH - 1) && (stretch % 3 != 2);
			sink_gaps = (stretch != N_STRETCH - 1) && (stretch % 4 != 3);
			if (stretch == 1) hold_asks++;   // back up the queue once
			eff = (STRETCH_TICKS[stretch] == 16'd0) ? 16'd1 : STRETCH_TICKS[stretch];
			sent = 0;
			while (sent < STRETCH_WORDS[stretch]) begin
				if ($urandom_range(0, 9) != 0) begin
					// well-formed: one command, then mostly empty ticks for its full length
					k = 3'($urandom_range(1, 6));
					span = CMD_PHASES[k] * eff;
					send_word(k, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
					sent++;
					for (fill = 1; fill < span && sent < STRETCH_WORDS[stretch]; fill++) begin
						pick = $urandom_range(0, 19);
						if (pick == 0) k = 3'($urandom_range(1, 6));   // lands while busy
						else if (pick == 1) k = KIND_UNUSED;
						else k = i2cbs_pkg::KIND_NONE;
						send_word(k, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, '0);
						sent++;
					end
				end else begin
					// noise: any kind at any moment
					send_word(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
						1'($urandom), 1'b0, '0);
					sent++;
				end
			end
		end

		// wind down: nothing more offered, wait for every owed word, then keep
		// watching in case the unit emits something extra
		idle_src(1);
		while (pin_words_due.size() != 0) @(negedge clk);
		repeat (6) @(posedge clk);
		if (pin_words_due.size() != 0)
			note_mismatch("words never returned", 16'(pin_words_due.size()), 16'd0);

		$display("summary: %0d words in, %0d checked, %0d commands completed, %0d turned away",
			words_in, words_out, cmds_done, cmds_turned);
		$display("summary: phase lengths 1000, 0, 1, 2, 3, 7 and 65535; %0d mismatches", fails);
		if (fails == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule
